### hdl/pspc_pkg.sv
package pspc_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CFG_SEND_EVENTS  = 3'd0;
   localparam logic [2:0] CFG_RAW_MODE     = 3'd1;
   localparam logic [2:0] CFG_IGNORE_NEG   = 3'd2;
   localparam logic [2:0] CFG_PRESS_SCALE  = 3'd3;
   localparam logic [2:0] CFG_TEMP_OFFSET  = 3'd4;
   localparam logic [2:0] CFG_RESTART      = 3'd5;

   localparam int CSR_DATA_W = 10;

   // shared serial divider geometry
   localparam int DIV_REM_W  = 25;
   localparam int DIV_BITS_W = 24;

   // iterations: divisor 2^23/scale first, then the rounded pressure quotient
   localparam logic [4:0] SCALE_STEPS = 5'd24;
   localparam logic [4:0] PRES_STEPS  = 5'd18;

   // twice the constant 10 of the temperature offset rounding
   localparam logic [DIV_REM_W-1:0] TEMP_DEN = 25'd20;

   localparam logic [8:0]  SCALE_RESET   = 9'd64;
   localparam logic [7:0]  RESTART_RESET = 8'd10;
   localparam logic [7:0]  COUNT_RESET   = 8'd1;
   localparam int          BUSY_BIT      = 3;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCALE = 5'b00010,
      S_LOAD  = 5'b00100,
      S_PRES  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic                  load;
      logic                  run;
      logic [DIV_REM_W-1:0]  rem_init;
      logic [DIV_BITS_W-1:0] bits;
      logic [DIV_REM_W-1:0]  den;
   } div_cmd_type;

   typedef struct packed {
      logic start_conversion;
      logic data_taken;
      logic sample_updated;
      logic send_event;
   } flags_type;

endpackage

### hdl/pspc_div.sv
module pspc_div (
   input  logic                               clock,
   input  pspc_pkg::div_cmd_type              cmd,
   output logic [pspc_pkg::DIV_BITS_W-1:0]    quo
);
   import pspc_pkg::*;

   logic [DIV_REM_W-1:0]  rem_ff,  rem_in;
   logic [DIV_BITS_W-1:0] bits_ff, bits_in;
   logic [DIV_BITS_W-1:0] quo_ff,  quo_in;
   logic [DIV_REM_W:0]    shifted;
   logic [DIV_REM_W:0]    diff;
   logic                  fits;

   // restoring division, one quotient bit per cycle while cmd.run is high
   always_comb begin
      shifted = {rem_ff, bits_ff[DIV_BITS_W-1]};
      diff    = shifted - {1'b0, cmd.den};
      fits    = shifted >= {1'b0, cmd.den};
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      if (cmd.load) begin
         rem_in  = cmd.rem_init;
         bits_in = cmd.bits;
         quo_in  = '0;
      end else if (cmd.run) begin
         rem_in  = fits ? diff[DIV_REM_W-1:0] : shifted[DIV_REM_W-1:0];
         bits_in = {bits_ff[DIV_BITS_W-2:0], 1'b0};
         quo_in  = {quo_ff[DIV_BITS_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
   end

   assign quo = quo_ff;

endmodule

### hdl/pressure_sensor_poll_convert.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  status_ok, status_byte, raw_pressure,
//                                             raw_temperature
// rsp       out        rsp_valid / rsp_stall  start_conversion, data_taken,
//                                             sample_updated, send_event,
//                                             pressure_q8, temperature_q8
// csr       in         csr_valid / csr_ready  index, data (ready always high)
//
// each request: accept, 24 steps of the serial divider for
// 2^23/scale (temperature offset rounding runs beside it), a load, 18 steps
// for the rounded pressure quotient, then the move into the output register.
// reset is synchronous; it clears control, configuration and kept samples.
// req_stall is high from the accept until the result moves to the output register;
// a stalled response holds there while the next request is accepted and worked on.
module pressure_sensor_poll_convert (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_status_ok,
   input  logic [7:0]                         req_status_byte,
   input  logic [23:0]                        req_raw_pressure,
   input  logic [15:0]                        req_raw_temperature,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_start_conversion,
   output logic                               rsp_data_taken,
   output logic                               rsp_sample_updated,
   output logic                               rsp_send_event,
   output logic signed [31:0]                 rsp_pressure_q8,
   output logic signed [16:0]                 rsp_temperature_q8,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [2:0]                         csr_index,
   input  logic [pspc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pspc_pkg::*;

   // configuration
   logic       send_events_ff, send_events_in;
   logic       raw_mode_ff,    raw_mode_in;
   logic       ignore_neg_ff,  ignore_neg_in;
   logic [8:0] scale_ff,       scale_in;
   logic [9:0] temp_off_ff,    temp_off_in;
   logic [7:0] restart_ff,     restart_in;

   // control and kept samples
   state_type  state_ff,     state_in;
   logic [4:0] cnt_ff,       cnt_in;
   logic       sensing_ff,   sensing_in;
   logic [7:0] countdown_ff, countdown_in;
   logic [23:0] last_p_ff,   last_p_in;
   logic [15:0] last_t_ff,   last_t_in;
   flags_type  flags_ff,     flags_in;
   logic [23:0] d_ff,        d_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   flags_type   rsp_flags_ff, rsp_flags_in;
   logic [31:0] rsp_p_ff,     rsp_p_in;
   logic [16:0] rsp_t_ff,     rsp_t_in;

   div_cmd_type             pdiv_cmd, tdiv_cmd;
   logic [DIV_BITS_W-1:0]   pdiv_quo, tdiv_quo;

   logic        accept;
   logic        ok, busy;
   logic [7:0]  cd_dec;
   logic        pchg;
   logic [8:0]  sc_eff;
   logic [9:0]  off_mag;
   logic [18:0] t_num;
   logic [23:0] p_eff;
   logic        p_neg;
   logic [23:0] p_mag;
   logic [32:0] p_num;
   logic [31:0] p_scaled;
   logic [16:0] t_adj;
   logic        out_free;

   pspc_div u_pdiv (.clock(clock), .cmd(pdiv_cmd), .quo(pdiv_quo));
   pspc_div u_tdiv (.clock(clock), .cmd(tdiv_cmd), .quo(tdiv_quo));

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // configuration writes
   always_comb begin
      send_events_in = send_events_ff;
      raw_mode_in    = raw_mode_ff;
      ignore_neg_in  = ignore_neg_ff;
      scale_in       = scale_ff;
      temp_off_in    = temp_off_ff;
      restart_in     = restart_ff;
      if (csr_valid) begin
         case (csr_index)
            CFG_SEND_EVENTS: send_events_in = csr_data[0];
            CFG_RAW_MODE:    raw_mode_in    = csr_data[0];
            CFG_IGNORE_NEG:  ignore_neg_in  = csr_data[0];
            CFG_PRESS_SCALE: scale_in       = csr_data[8:0];
            CFG_TEMP_OFFSET: temp_off_in    = csr_data[9:0];
            CFG_RESTART:     restart_in     = csr_data[7:0];
            default: ;
         endcase
      end
   end

   // operands of the arithmetic
   always_comb begin
      sc_eff  = (scale_ff == 9'd0) ? 9'd1 : scale_ff;
      off_mag = temp_off_ff[9] ? (~temp_off_ff + 10'd1) : temp_off_ff;
      t_num   = {off_mag, 9'd0} + 19'd10;
      p_eff   = (last_p_ff[23] && ignore_neg_ff) ? 24'd0 : last_p_ff;
      p_neg   = p_eff[23];
      p_mag   = p_neg ? (~p_eff + 24'd1) : p_eff;
      p_num   = {p_mag, 9'd0} + {9'd0, pdiv_quo};
      p_scaled = p_neg ? (32'd0 - {14'd0, pdiv_quo[17:0]}) : {14'd0, pdiv_quo[17:0]};
      t_adj   = temp_off_ff[9] ? (17'd0 - {2'd0, tdiv_quo[14:0]})
                               : {2'd0, tdiv_quo[14:0]};
   end

   // divider commands
   always_comb begin
      pdiv_cmd = '0;
      tdiv_cmd = '0;
      tdiv_cmd.den = TEMP_DEN;
      case (state_ff)
         S_IDLE: begin
            pdiv_cmd.load = accept;
            pdiv_cmd.bits = 24'h800000;
            tdiv_cmd.load = accept;
            tdiv_cmd.bits = {5'd0, t_num};
         end
         S_SCALE: begin
            pdiv_cmd.run = 1'b1;
            pdiv_cmd.den = {16'd0, sc_eff};
            tdiv_cmd.run = 1'b1;
         end
         S_LOAD: begin
            // numerator 2*|p|*256 + d, upper bits preloaded as remainder
            pdiv_cmd.load     = 1'b1;
            pdiv_cmd.rem_init = {10'd0, p_num[32:18]};
            pdiv_cmd.bits     = {p_num[17:0], 6'd0};
         end
         S_PRES: begin
            pdiv_cmd.run = 1'b1;
            pdiv_cmd.den = {d_ff, 1'b0};
         end
         default: ;
      endcase
   end

   // request control and sequencing
   always_comb begin
      ok   = req_status_ok;
      busy = req_status_byte[BUSY_BIT];
      cd_dec = countdown_ff - 8'd1;
      pchg = req_raw_pressure != last_p_ff;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sensing_in   = sensing_ff;
      countdown_in = countdown_ff;
      last_p_in    = last_p_ff;
      last_t_in    = last_t_ff;
      flags_in     = flags_ff;
      d_in         = d_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_p_in     = rsp_p_ff;
      rsp_t_in     = rsp_t_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               flags_in = '0;
               if (!sensing_ff) begin
                  countdown_in = cd_dec;
                  if (cd_dec == 8'd0 && ok && !busy) begin
                     flags_in.start_conversion = 1'b1;
                     sensing_in   = 1'b1;
                     countdown_in = restart_ff;
                  end
               end else if (ok && !busy) begin
                  flags_in.data_taken = 1'b1;
                  sensing_in = 1'b0;
                  if (pchg || req_raw_temperature != last_t_ff) begin
                     last_p_in = req_raw_pressure;
                     last_t_in = req_raw_temperature;
                     flags_in.sample_updated = 1'b1;
                     flags_in.send_event     = send_events_ff && pchg;
                  end
               end
               cnt_in   = '0;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SCALE_STEPS - 5'd1) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            d_in     = pdiv_quo;
            cnt_in   = '0;
            state_in = S_PRES;
         end
         S_PRES: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == PRES_STEPS - 5'd1) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_flags_in = flags_ff;
               if (raw_mode_ff) begin
                  rsp_p_in = {p_eff, 8'd0};
                  rsp_t_in = {last_t_ff[15], last_t_ff};
               end else begin
                  rsp_p_in = p_scaled;
                  rsp_t_in = {last_t_ff[15], last_t_ff} + t_adj;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_events_ff <= 1'b0;
         raw_mode_ff    <= 1'b0;
         ignore_neg_ff  <= 1'b0;
         scale_ff       <= SCALE_RESET;
         temp_off_ff    <= '0;
         restart_ff     <= RESTART_RESET;
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         sensing_ff     <= 1'b0;
         countdown_ff   <= COUNT_RESET;
         last_p_ff      <= '0;
         last_t_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         send_events_ff <= send_events_in;
         raw_mode_ff    <= raw_mode_in;
         ignore_neg_ff  <= ignore_neg_in;
         scale_ff       <= scale_in;
         temp_off_ff    <= temp_off_in;
         restart_ff     <= restart_in;
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         sensing_ff     <= sensing_in;
         countdown_ff   <= countdown_in;
         last_p_ff      <= last_p_in;
         last_t_ff      <= last_t_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff     <= flags_in;
      d_ff         <= d_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_p_ff     <= rsp_p_in;
      rsp_t_ff     <= rsp_t_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_start_conversion = rsp_flags_ff.start_conversion;
   assign rsp_data_taken       = rsp_flags_ff.data_taken;
   assign rsp_sample_updated   = rsp_flags_ff.sample_updated;
   assign rsp_send_event       = rsp_flags_ff.send_event;
   assign rsp_pressure_q8      = rsp_p_ff;
   assign rsp_temperature_q8   = rsp_t_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_SCALE)
      else $error("accepted request did not start the divider");
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PRES |-> d_ff != 24'd0)
      else $error("pressure divisor is zero");
   a_event_needs_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_event |-> rsp_sample_updated)
      else $error("event without sample update");
   a_start_xor_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_start_conversion && rsp_data_taken))
      else $error("start and data taken in one request");
   a_hold_unfree: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !out_free |=> state_ff == S_DONE)
      else $error("result left while output register busy");
`endif

endmodule
